// ----- hdl/mcw_pkg.sv -----
// ----------------------------------------------------------------------------
// mcw_pkg: shared types, constants and helpers for the coordinate warp
// Payload structs, register codes, fill codes and Q8.24 saturation.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int COORD_BITS    = 12;                // source coordinate integer bits
  localparam int FRAC_BITS     = 8;                 // source coordinate fraction bits
  localparam int MAX_DEPTH_DEF = 50;                // default number of iteration cells
  localparam int SIZE_W        = COORD_BITS + 1;    // clamped image size, 1 .. 2^COORD_BITS
  localparam int MOD_W         = SIZE_W + FRAC_BITS; // size * 256
  localparam int VAL_W         = COORD_BITS + FRAC_BITS;
  localparam int NUM_W         = 41;                // |(z - min) * 256|
  localparam int DEN_W         = 32;                // |step|
  localparam int POS_W         = 43;                // signed position, 1/256 pixel
  localparam int ORG_W         = 13;                // signed selection origin

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } cmd_t;

  typedef struct packed {
    logic [11:0] src_x;
    logic [7:0]  src_x_frac;
    logic [11:0] src_y;
    logic [7:0]  src_y_frac;
    logic [1:0]  fill_kind;
  } result_t;

  // One point of the orbit plus what travels alongside it
  typedef struct packed {
    logic signed [31:0]      zx;
    logic signed [31:0]      zy;
    logic signed [31:0]      cx;
    logic signed [31:0]      cy;
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
  } orbit_t;

  typedef enum logic [2:0] {
    REG_X_MIN        = 3'd0,
    REG_Y_MIN        = 3'd1,
    REG_STEP_X       = 3'd2,
    REG_STEP_Y       = 3'd3,
    REG_DEPTH        = 3'd4,
    REG_OUTSIDE_MODE = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_WRAP   = 2'd0;
  localparam logic [1:0] FILL_SAMPLE = 2'd0;

  localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- hdl/mandelbrot_coordinate_warp_top.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_coordinate_warp_top: fractal trace coordinate warp
// Maps each destination pixel through z = z*z + c and back to a source
// coordinate with 8 fractional bits, with wrap or fill outside the image.
// ----------------------------------------------------------------------------
//
//   channel   | signals                               | transaction
//   ----------+---------------------------------------+---------------------------
//   command   | start, busy, cmd                      | edge with start & !busy
//   result    | done, result                          | edge ending the done cycle
//   config    | psel penable pwrite paddr pwdata      | edge with psel&penable&
//             | prdata pready                         |   pwrite&pready
//
// One pixel is taken every cycle; busy never rises.
// The pipeline holds two front-end
// stages (multiply, offset and saturate), two stages per iteration cell, a
// numerator stage, a 41-step divider chain, two fix-up stages, a 43-step modulo
// chain and the output reg.
// Sync reset clears all valid bits and the registers; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Registers must be written only while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_coordinate_warp_top #(
  parameter int MAX_DEPTH = mcw_pkg::MAX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mcw_pkg::cmd_t    cmd,
  output logic             done,
  output mcw_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mcw_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int LAT     = 2 + 2 * MAX_DEPTH + 1 + NUM_W + 1 + 1 + POS_W + 1;
  localparam int DSIDE_W = 2 + 2 * ORG_W;          // numerator signs, origins
  localparam int MSIDE_W = 3 + 2 * VAL_W;          // in bounds, signs, positions
  localparam logic [SIZE_W-1:0] SIZE_LIM = SIZE_W'(1 << COORD_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] x_min, y_min, step_x, step_y;
  logic [5:0]         iteration_depth;
  logic [1:0]         outside_mode;
  logic [12:0]        image_width, image_height;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min           <= -32'sd16777216;
      y_min           <= -32'sd16777216;
      step_x          <= 32'sd98304;
      step_y          <= 32'sd131072;
      iteration_depth <= 6'd3;
      outside_mode    <= MODE_WRAP;
      image_width     <= 13'd256;
      image_height    <= 13'd256;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_X_MIN:        x_min           <= $signed(pwdata);
        REG_Y_MIN:        y_min           <= $signed(pwdata);
        REG_STEP_X:       step_x          <= $signed(pwdata);
        REG_STEP_Y:       step_y          <= $signed(pwdata);
        REG_DEPTH:        iteration_depth <= pwdata[5:0];
        REG_OUTSIDE_MODE: outside_mode    <= pwdata[1:0];
        REG_IMAGE_WIDTH:  image_width     <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_X_MIN:        prdata = x_min;
      REG_Y_MIN:        prdata = y_min;
      REG_STEP_X:       prdata = step_x;
      REG_STEP_Y:       prdata = step_y;
      REG_DEPTH:        prdata = {26'd0, iteration_depth};
      REG_OUTSIDE_MODE: prdata = {30'd0, outside_mode};
      REG_IMAGE_WIDTH:  prdata = {19'd0, image_width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, image_height};
      default:          prdata = 32'd0;
    endcase
  end

  // Values derived from the static registers
  logic [DEPTH_W-1:0] depth_eff;
  logic [SIZE_W-1:0]  w_cl, h_cl;
  logic [MOD_W-1:0]   m_x, m_y;
  logic [DEN_W-1:0]   dmag_x, dmag_y;

  always_comb begin
    depth_eff = (int'(iteration_depth) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                    : DEPTH_W'(iteration_depth);
    w_cl = (image_width == '0) ? SIZE_W'(1)
         : (image_width > SIZE_LIM) ? SIZE_LIM : image_width[SIZE_W-1:0];
    h_cl = (image_height == '0) ? SIZE_W'(1)
         : (image_height > SIZE_LIM) ? SIZE_LIM : image_height[SIZE_W-1:0];
    m_x    = {w_cl, {FRAC_BITS{1'b0}}};
    m_y    = {h_cl, {FRAC_BITS{1'b0}}};
    dmag_x = step_x[31] ? DEN_W'(-step_x) : DEN_W'(step_x);
    dmag_y = step_y[31] ? DEN_W'(-step_y) : DEN_W'(step_y);
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Front end: c = sat(min + index * step), selection origin
  // --------------------------------------------------------------------------
  logic                    f1_valid;
  logic signed [44:0]      f1_prod_x, f1_prod_y;
  logic signed [ORG_W-1:0] f1_org_x, f1_org_y;
  logic                    f2_valid;
  orbit_t                  f2_z;
  logic signed [31:0]      c_x, c_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= start & ~busy;
    end
    f1_prod_x <= $signed({1'b0, cmd.col}) * step_x;
    f1_prod_y <= $signed({1'b0, cmd.row}) * step_y;
    f1_org_x  <= $signed({1'b0, cmd.pixel_x}) - $signed({1'b0, cmd.col});
    f1_org_y  <= $signed({1'b0, cmd.pixel_y}) - $signed({1'b0, cmd.row});
  end

  always_comb begin
    c_x = sat32($signed({{3{f1_prod_x[44]}}, f1_prod_x}) + $signed({{16{x_min[31]}}, x_min}));
    c_y = sat32($signed({{3{f1_prod_y[44]}}, f1_prod_y}) + $signed({{16{y_min[31]}}, y_min}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
    f2_z.zx    <= c_x;
    f2_z.zy    <= c_y;
    f2_z.cx    <= c_x;
    f2_z.cy    <= c_y;
    f2_z.org_x <= f1_org_x;
    f2_z.org_y <= f1_org_y;
  end

  // --------------------------------------------------------------------------
  // Iteration chain: cell k runs round k when k < depth, else passes z on
  // --------------------------------------------------------------------------
  orbit_t chain_z [0:MAX_DEPTH];
  logic   chain_v [0:MAX_DEPTH];

  assign chain_z[0] = f2_z;
  assign chain_v[0] = f2_valid;

  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_iter
    mcw_iter_cell #(.IDX(k), .DW(DEPTH_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_v[k]),
      .in_z      (chain_z[k]),
      .depth     (depth_eff),
      .out_valid (chain_v[k+1]),
      .out_z     (chain_z[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Back map: numerator (z - min) * 256 as sign and magnitude
  // --------------------------------------------------------------------------
  orbit_t             zf;
  logic signed [32:0] dz_x, dz_y;
  logic signed [40:0] num_x, num_y;
  logic               b_valid;
  logic [NUM_W-1:0]   b_mag_x, b_mag_y;
  logic [DSIDE_W-1:0] b_side;

  always_comb begin
    zf    = chain_z[MAX_DEPTH];
    dz_x  = $signed({zf.zx[31], zf.zx}) - $signed({x_min[31], x_min});
    dz_y  = $signed({zf.zy[31], zf.zy}) - $signed({y_min[31], y_min});
    num_x = $signed({dz_x, 8'd0});
    num_y = $signed({dz_y, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= chain_v[MAX_DEPTH];
    end
    b_mag_x <= num_x[40] ? NUM_W'(-num_x) : NUM_W'(num_x);
    b_mag_y <= num_y[40] ? NUM_W'(-num_y) : NUM_W'(num_y);
    b_side  <= {num_x[40], num_y[40], zf.org_x, zf.org_y};
  end

  // Divider chain, one quotient bit per cell
  logic [NUM_W-1:0]   dv_work_x [0:NUM_W];
  logic [NUM_W-1:0]   dv_work_y [0:NUM_W];
  logic [DEN_W-1:0]   dv_rem_x  [0:NUM_W];
  logic [DEN_W-1:0]   dv_rem_y  [0:NUM_W];
  logic [DSIDE_W-1:0] dv_side   [0:NUM_W];
  logic               dv_v      [0:NUM_W];

  assign dv_work_x[0] = b_mag_x;
  assign dv_work_y[0] = b_mag_y;
  assign dv_rem_x[0]  = '0;
  assign dv_rem_y[0]  = '0;
  assign dv_side[0]   = b_side;
  assign dv_v[0]      = b_valid;

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    mcw_div_cell #(.NW(NUM_W), .DW(DEN_W), .SW(DSIDE_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (dv_v[k]),
      .in_work_x  (dv_work_x[k]),
      .in_rem_x   (dv_rem_x[k]),
      .in_work_y  (dv_work_y[k]),
      .in_rem_y   (dv_rem_y[k]),
      .div_x      (dmag_x),
      .div_y      (dmag_y),
      .in_side    (dv_side[k]),
      .out_valid  (dv_v[k+1]),
      .out_work_x (dv_work_x[k+1]),
      .out_rem_x  (dv_rem_x[k+1]),
      .out_work_y (dv_work_y[k+1]),
      .out_rem_y  (dv_rem_y[k+1]),
      .out_side   (dv_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Floor quotient, add origin * 256
  // --------------------------------------------------------------------------
  logic                    nneg_x, nneg_y;
  logic signed [ORG_W-1:0] o_x, o_y;
  logic signed [POS_W-1:0] q_x, q_y, qf_x, qf_y, pos_x, pos_y;
  logic                    p1_valid;
  logic signed [POS_W-1:0] p1_x, p1_y;

  always_comb begin
    {nneg_x, nneg_y, o_x, o_y} = dv_side[NUM_W];
    q_x = $signed({2'b00, dv_work_x[NUM_W]});
    q_y = $signed({2'b00, dv_work_y[NUM_W]});
    if (dmag_x == '0) begin
      qf_x = '0;
    end else if (nneg_x ^ step_x[31]) begin
      qf_x = -q_x - $signed({{(POS_W-1){1'b0}}, (dv_rem_x[NUM_W] != '0)});
    end else begin
      qf_x = q_x;
    end
    if (dmag_y == '0) begin
      qf_y = '0;
    end else if (nneg_y ^ step_y[31]) begin
      qf_y = -q_y - $signed({{(POS_W-1){1'b0}}, (dv_rem_y[NUM_W] != '0)});
    end else begin
      qf_y = q_y;
    end
    pos_x = qf_x + $signed({{(POS_W-ORG_W-8){o_x[ORG_W-1]}}, o_x, 8'd0});
    pos_y = qf_y + $signed({{(POS_W-ORG_W-8){o_y[ORG_W-1]}}, o_y, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= dv_v[NUM_W];
    end
    p1_x <= pos_x;
    p1_y <= pos_y;
  end

  // Bounds test and magnitudes for the wrap
  logic               inb;
  logic               p2_valid;
  logic [POS_W-1:0]   p2_mag_x, p2_mag_y;
  logic [MSIDE_W-1:0] p2_side;

  always_comb begin
    inb = !p1_x[POS_W-1] && (p1_x < $signed({{(POS_W-MOD_W){1'b0}}, m_x}))
       && !p1_y[POS_W-1] && (p1_y < $signed({{(POS_W-MOD_W){1'b0}}, m_y}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_mag_x <= p1_x[POS_W-1] ? POS_W'(-p1_x) : POS_W'(p1_x);
    p2_mag_y <= p1_y[POS_W-1] ? POS_W'(-p1_y) : POS_W'(p1_y);
    p2_side  <= {inb, p1_x[POS_W-1], p1_y[POS_W-1], p1_x[VAL_W-1:0], p1_y[VAL_W-1:0]};
  end

  // Modulo chain: remainder of |pos| by size * 256
  logic [POS_W-1:0]   md_work_x [0:POS_W];
  logic [POS_W-1:0]   md_work_y [0:POS_W];
  logic [MOD_W-1:0]   md_rem_x  [0:POS_W];
  logic [MOD_W-1:0]   md_rem_y  [0:POS_W];
  logic [MSIDE_W-1:0] md_side   [0:POS_W];
  logic               md_v      [0:POS_W];

  assign md_work_x[0] = p2_mag_x;
  assign md_work_y[0] = p2_mag_y;
  assign md_rem_x[0]  = '0;
  assign md_rem_y[0]  = '0;
  assign md_side[0]   = p2_side;
  assign md_v[0]      = p2_valid;

  for (genvar k = 0; k < POS_W; k++) begin : g_mod
    mcw_div_cell #(.NW(POS_W), .DW(MOD_W), .SW(MSIDE_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (md_v[k]),
      .in_work_x  (md_work_x[k]),
      .in_rem_x   (md_rem_x[k]),
      .in_work_y  (md_work_y[k]),
      .in_rem_y   (md_rem_y[k]),
      .div_x      (m_x),
      .div_y      (m_y),
      .in_side    (md_side[k]),
      .out_valid  (md_v[k+1]),
      .out_work_x (md_work_x[k+1]),
      .out_rem_x  (md_rem_x[k+1]),
      .out_work_y (md_work_y[k+1]),
      .out_rem_y  (md_rem_y[k+1]),
      .out_side   (md_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output selection: in bounds, wrap, or fill
  // --------------------------------------------------------------------------
  logic             f_inb, f_neg_x, f_neg_y;
  logic [VAL_W-1:0] f_pos_x, f_pos_y;
  logic [MOD_W-1:0] wr_x, wr_y;
  logic [VAL_W-1:0] v_x, v_y;
  logic [1:0]       fill;

  always_comb begin
    {f_inb, f_neg_x, f_neg_y, f_pos_x, f_pos_y} = md_side[POS_W];
    wr_x = (f_neg_x && md_rem_x[POS_W] != '0) ? m_x - md_rem_x[POS_W] : md_rem_x[POS_W];
    wr_y = (f_neg_y && md_rem_y[POS_W] != '0) ? m_y - md_rem_y[POS_W] : md_rem_y[POS_W];
    if (f_inb) begin
      v_x  = f_pos_x;
      v_y  = f_pos_y;
      fill = FILL_SAMPLE;
    end else if (outside_mode == MODE_WRAP) begin
      v_x  = wr_x[VAL_W-1:0];
      v_y  = wr_y[VAL_W-1:0];
      fill = FILL_SAMPLE;
    end else begin
      v_x  = '0;
      v_y  = '0;
      fill = outside_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= md_v[POS_W];
    end
    result.src_x      <= v_x[VAL_W-1:FRAC_BITS];
    result.src_x_frac <= v_x[FRAC_BITS-1:0];
    result.src_y      <= v_y[VAL_W-1:FRAC_BITS];
    result.src_y_frac <= v_y[FRAC_BITS-1:0];
    result.fill_kind  <= fill;
  end

`ifndef SYNTHESIS
  // every result traces back to an earlier accepted command
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching command");

  // fill results carry no coordinate
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fill_kind != FILL_SAMPLE) |->
      (result.src_x == '0 && result.src_x_frac == '0 &&
       result.src_y == '0 && result.src_y_frac == '0))
    else $error("fill result with nonzero coordinate");

  // reset flushes the whole pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");
`endif

endmodule

// ----- hdl/mcw_iter_cell.sv -----
// ----------------------------------------------------------------------------
// mcw_iter_cell: one round of z = z*z + c
// Stage A registers the three products, stage B sums and saturates.
// ----------------------------------------------------------------------------
module mcw_iter_cell #(
  parameter int IDX = 0,
  parameter int DW  = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mcw_pkg::orbit_t in_z,
  input  logic [DW-1:0]  depth,
  output logic           out_valid,
  output mcw_pkg::orbit_t out_z
);
  import mcw_pkg::*;

  logic               a_valid;
  logic               a_act;
  orbit_t             a_z;
  logic signed [63:0] a_xx, a_yy, a_xy;
  logic signed [63:0] sh_xx, sh_yy, sh_xy;
  logic signed [47:0] sum_x, sum_y;
  orbit_t             z_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_act <= (depth > DW'(IDX));
    a_z   <= in_z;
    a_xx  <= in_z.zx * in_z.zx;
    a_yy  <= in_z.zy * in_z.zy;
    a_xy  <= in_z.zx * in_z.zy;
  end

  // arithmetic shifts floor toward minus infinity; 2*x*y is a shift by 23
  always_comb begin
    sh_xx = a_xx >>> 24;
    sh_yy = a_yy >>> 24;
    sh_xy = a_xy >>> 23;
    sum_x = $signed(sh_xx[47:0]) - $signed(sh_yy[47:0])
          + $signed({{16{a_z.cx[31]}}, a_z.cx});
    sum_y = $signed(sh_xy[47:0]) + $signed({{16{a_z.cy[31]}}, a_z.cy});
    z_next = a_z;
    if (a_act) begin
      z_next.zx = sat32(sum_x);
      z_next.zy = sat32(sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_z <= z_next;
  end

endmodule

// ----- hdl/mcw_div_cell.sv -----
// ----------------------------------------------------------------------------
// mcw_div_cell: one restoring division step on two lanes
// Shifts one dividend bit into the partial remainder, develops one quotient bit.
// ----------------------------------------------------------------------------
module mcw_div_cell #(
  parameter int NW = 41,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_work_x,
  input  logic [DW-1:0] in_rem_x,
  input  logic [NW-1:0] in_work_y,
  input  logic [DW-1:0] in_rem_y,
  input  logic [DW-1:0] div_x,
  input  logic [DW-1:0] div_y,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_work_x,
  output logic [DW-1:0] out_rem_x,
  output logic [NW-1:0] out_work_y,
  output logic [DW-1:0] out_rem_y,
  output logic [SW-1:0] out_side
);

  logic [DW:0] trial_x, trial_y, diff_x, diff_y;
  logic        ge_x, ge_y;

  always_comb begin
    trial_x = {in_rem_x, in_work_x[NW-1]};
    trial_y = {in_rem_y, in_work_y[NW-1]};
    diff_x  = trial_x - {1'b0, div_x};
    diff_y  = trial_y - {1'b0, div_y};
    ge_x    = (trial_x >= {1'b0, div_x});
    ge_y    = (trial_y >= {1'b0, div_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_work_x <= {in_work_x[NW-2:0], ge_x};
    out_work_y <= {in_work_y[NW-2:0], ge_y};
    out_rem_x  <= ge_x ? diff_x[DW-1:0] : trial_x[DW-1:0];
    out_rem_y  <= ge_y ? diff_y[DW-1:0] : trial_y[DW-1:0];
    out_side   <= in_side;
  end

endmodule

// ----- tb/sv/tb_mandelbrot_coordinate_warp_top.sv -----
// ----------------------------------------------------------------------------
// tb_mandelbrot_coordinate_warp_top: self-checking bench for the coordinate warp
// Drives pixel commands and register writes and predicts every result in Q8.24.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mandelbrot_coordinate_warp_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcw_pkg::*;

  // Outside modes other than wrap (the package names only wrap)
  localparam logic [1:0] MODE_TRANSPARENT = 2'd1;
  localparam logic [1:0] MODE_BLACK       = 2'd2;
  localparam logic [1:0] MODE_WHITE       = 2'd3;
  localparam int         PIPE_LAT         = 2 * MAX_DEPTH_DEF + 90;
  localparam int         DEPTH_CAP        = MAX_DEPTH_DEF;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the registers, predicts each pixel, checks results
  // --------------------------------------------------------------------------
  class warp_scoreboard;
    longint  x_min, y_min, step_x, step_y;
    int      depth;
    logic [1:0]  mode;
    int      img_w, img_h;
    result_t expected_q[$];
    int      mismatches;

    function new();
      x_min = -16777216; y_min = -16777216;
      step_x = 98304;    step_y = 131072;
      depth = 3; mode = MODE_WRAP; img_w = 256; img_h = 256;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_X_MIN:        x_min  = longint'($signed(v));
        REG_Y_MIN:        y_min  = longint'($signed(v));
        REG_STEP_X:       step_x = longint'($signed(v));
        REG_STEP_Y:       step_y = longint'($signed(v));
        REG_DEPTH:        depth  = int'(v[5:0]);
        REG_OUTSIDE_MODE: mode   = v[1:0];
        REG_IMAGE_WIDTH:  img_w  = int'(v[12:0]);
        REG_IMAGE_HEIGHT: img_h  = int'(v[12:0]);
        default: ;
      endcase
    endfunction

    static function longint sat_q824(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint floor_div(longint n, longint d);
      longint q;
      if (d == 0) return 0;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q--;
      return q;
    endfunction

    static function longint floor_mod(longint n, longint m);
      longint r;
      r = n % m;
      if (r < 0) r += m;
      return r;
    endfunction

    static function longint clamp_size(int s);
      if (s < 1) return 1;
      if (s > (1 << COORD_BITS)) return 1 << COORD_BITS;
      return s;
    endfunction

    // Orbit of c under z*z + c, then back to 1/256 source pixels
    function result_t warp_pixel(cmd_t c);
      longint col, row, ox, oy, cx, cy, zx, zy, nx, ny, w, h, px, py;
      int n;
      logic [1:0] fill;
      result_t r;
      col = c.col; row = c.row;
      ox = longint'(c.pixel_x) - col;
      oy = longint'(c.pixel_y) - row;
      cx = sat_q824(x_min + col * step_x);
      cy = sat_q824(y_min + row * step_y);
      zx = cx; zy = cy;
      n = (depth > DEPTH_CAP) ? DEPTH_CAP : depth;
      for (int i = 0; i < n; i++) begin
        nx = sat_q824(((zx * zx) >>> 24) - ((zy * zy) >>> 24) + cx);
        ny = sat_q824(((zx * zy) >>> 23) + cy);
        zx = nx; zy = ny;
      end
      w = clamp_size(img_w);
      h = clamp_size(img_h);
      px = floor_div((zx - x_min) * 256, step_x) + ox * 256;
      py = floor_div((zy - y_min) * 256, step_y) + oy * 256;
      fill = FILL_SAMPLE;
      if (!(px >= 0 && px < w * 256 && py >= 0 && py < h * 256)) begin
        if (mode == MODE_WRAP) begin
          px = floor_mod(px, w * 256);
          py = floor_mod(py, h * 256);
        end else begin
          fill = mode;
        end
      end
      r = '0;
      r.fill_kind = fill;
      if (fill == FILL_SAMPLE) begin
        r.src_x = px[19:8]; r.src_x_frac = px[7:0];
        r.src_y = py[19:8]; r.src_y_frac = py[7:0];
      end
      return r;
    endfunction

    function void note_pixel(cmd_t c);
      expected_q.push_back(warp_pixel(c));
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  warp_scoreboard sb = new();
  int          idle_pct = 13;    // sender idle chance per transaction, percent

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mandelbrot_coordinate_warp_top uut (
    .clk, .rst, .start, .busy, .cmd, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Monitors: commands accepted on start & !busy, results on done.
  // Sampled at the edge, so they see values driven before it.
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_pixel(cmd);
    if (!rst && done) sb.check_result(result);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // APB write: setup cycle, then access cycle until pready
  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_window(logic [31:0] xmin, logic [31:0] ymin, logic [31:0] sx,
                            logic [31:0] sy, logic [5:0] dep, logic [1:0] md,
                            logic [12:0] w, logic [12:0] h);
    reg_write(REG_X_MIN, xmin);
    reg_write(REG_Y_MIN, ymin);
    reg_write(REG_STEP_X, sx);
    reg_write(REG_STEP_Y, sy);
    reg_write(REG_DEPTH, {26'd0, dep});
    reg_write(REG_OUTSIDE_MODE, {30'd0, md});
    reg_write(REG_IMAGE_WIDTH, {19'd0, w});
    reg_write(REG_IMAGE_HEIGHT, {19'd0, h});
    @(posedge clk);
  endtask

  // One pixel transaction; start stays high across back-to-back transactions
  task automatic send_pixel(cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start, then wait for every prediction to be matched
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic cmd_t pick_pixel();
    cmd_t c;
    c.col = 12'($urandom); c.row = 12'($urandom);
    c.pixel_x = 12'($urandom); c.pixel_y = 12'($urandom);
    // mostly a consistent selection with small offsets, some pure noise
    if ($urandom_range(99) < 70) begin
      c.col = 12'($urandom_range(0, 255));
      c.row = 12'($urandom_range(0, 255));
      c.pixel_x = 12'(c.col + $urandom_range(0, 300));
      c.pixel_y = 12'(c.row + $urandom_range(0, 300));
    end
    return c;
  endfunction

  function automatic logic [31:0] pick_step();
    logic [31:0] s;
    case ($urandom_range(0, 5))
      0:       s = $urandom;
      1:       s = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: s = $urandom_range(1024, 1 << 20);
    endcase
    if ($urandom_range(3) == 0) s = -s;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cmd_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels at reset settings: field extremes, inconsistent origin
    send_pixel('{12'd0, 12'd0, 12'd0, 12'd0});
    send_pixel('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    send_pixel('{12'hFFF, 12'hFFF, 12'd0, 12'd0});
    send_pixel('{12'd0, 12'd0, 12'hFFF, 12'hFFF});
    send_pixel('{12'd10, 12'd8, 12'd40, 12'd30});
    send_pixel('{12'd20, 12'd15, 12'd20, 12'd15});
    drain();

    // Depth zero, fill modes, zero steps, zero and oversized sizes, extremes
    set_window(32'hFF00_0000, 32'hFF00_0000, 32'h0001_8000, 32'h0002_0000,
               6'd0, MODE_TRANSPARENT, 13'd256, 13'd256);
    send_pixel('{12'd5, 12'd5, 12'd5, 12'd5});
    send_pixel('{12'd200, 12'd200, 12'd4000, 12'd4000});
    drain();
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0,
               6'd63, MODE_BLACK, 13'd0, 13'd8191);
    send_pixel('{12'hFFF, 12'd0, 12'hFFF, 12'd0});
    send_pixel('{12'd1, 12'd1, 12'd0, 12'd0});
    drain();
    set_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               6'd50, MODE_WHITE, 13'd4096, 13'd1);
    send_pixel('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    send_pixel('{12'd0, 12'd0, 12'd0, 12'd0});
    drain();
    set_window(32'hFE00_0000, 32'hFE00_0000, 32'h0000_4000, 32'h0000_4000,
               6'd1, MODE_WRAP, 13'd4097, 13'd1);
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel());
    drain();

    // Random phases: sender idles 13%, then 46%, then not at all
    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = (ph < 8) ? 13 : (ph < 16) ? 46 : 0;
      set_window(($urandom_range(3) == 0) ? $urandom
                   : 32'hFD00_0000 + $urandom_range(0, 32'h0300_0000),
                 ($urandom_range(3) == 0) ? $urandom
                   : 32'hFD00_0000 + $urandom_range(0, 32'h0300_0000),
                 pick_step(), pick_step(),
                 ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6)),
                 2'($urandom),
                 ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096)),
                 ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096)));
      for (int i = 0; i < 54; i++) begin
        c = pick_pixel();
        send_pixel(c);
      end
      drain();
    end

    repeat (PIPE_LAT) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** mandelbrot_coordinate_warp_top: PASSED **");
    end else begin
      $display("** mandelbrot_coordinate_warp_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** mandelbrot_coordinate_warp_top: FAILED **");
    $finish;
  end

endmodule
